>>> design/afs_pkg.sv
// Shared types, field widths and codes of the animation frame sequencer.
// Used by every module of the block but afs_alu; depends on nothing.
package afs_pkg;

	// Field widths of the requests, results and registers.
	localparam int FRAME_W  = 20;
	localparam int DELTA_W  = 10;
	localparam int RATE_W   = 16;
	localparam int OP_W     = 3;
	localparam int MODE_W   = 2;
	localparam int RUN_W    = 2;
	localparam int PROD_W   = RATE_W + DELTA_W;
	// Fraction bits of the rate*delta product (Q8.8 times Q2.8).
	localparam int PROD_FRAC = 16;

	// Default parameter values of the top level.
	localparam int DEF_FRAME_BITS = 20;
	localparam int DEF_FRAC_BITS  = 8;

	// Configuration port.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_MAX  = 2'd1;
	localparam logic [1:0] REG_MIN  = 2'd2;
	localparam logic [1:0] REG_RATE = 2'd3;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

	// Request op codes.
	localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OP_W-1:0] OP_PLAY     = 3'd1;
	localparam logic [OP_W-1:0] OP_REQ_STOP = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP     = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART  = 3'd4;

	// Play modes.
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALT  = 2'd3;

	// Run states.
	localparam logic [RUN_W-1:0] RUN_STOPPED  = 2'd0;
	localparam logic [RUN_W-1:0] RUN_PLAYING  = 2'd1;
	localparam logic [RUN_W-1:0] RUN_STOP_REQ = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DELTA_W-1:0] delta;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [RUN_W-1:0]   run_status;
		logic               going_back;
	} out_item_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FRAME_W-1:0] max_frame;
		logic [FRAME_W-1:0] min_frame;
		logic [RATE_W-1:0]  rate;
	} cfg_t;

endpackage

>>> design/afs_alu.sv
// Shared add/subtract unit of the frame sequencer, with borrow and zero flags.
// Depends on nothing.
module afs_alu #(
	parameter int W = 21
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         borrow,
	output logic         zero
);

	logic [W:0] full;

	assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res    = full[W-1:0];
	// On a subtraction a missing carry means a < b.
	assign borrow = sub & ~full[W];
	assign zero   = (full[W-1:0] == {W{1'b0}});

endmodule

>>> design/afs_regs.sv
// APB-style configuration registers of the frame sequencer.
// Depends on afs_pkg.
module afs_regs #(
	parameter int FRAME_BITS = afs_pkg::DEF_FRAME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afs_pkg::ADDR_W-1:0]  paddr,
	input  logic [afs_pkg::DATA_W-1:0]  pwdata,
	output logic [afs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output afs_pkg::cfg_t               cfg
);

	localparam int MW = (FRAME_BITS < afs_pkg::FRAME_W) ? FRAME_BITS : afs_pkg::FRAME_W;
	localparam logic [afs_pkg::FRAME_W-1:0] FMASK =
		{afs_pkg::FRAME_W{1'b1}} >> (afs_pkg::FRAME_W - MW);

	afs_pkg::cfg_t cfg_q;
	logic [1:0]    idx;
	logic          wr;

	assign idx    = paddr[afs_pkg::ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Frame bounds are trimmed to the position width when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= afs_pkg::MODE_FWD;
			cfg_q.max_frame <= '0;
			cfg_q.min_frame <= '0;
			cfg_q.rate      <= afs_pkg::RATE_RESET;
		end else if (wr) begin
			case (idx)
				afs_pkg::REG_MODE: cfg_q.mode <= pwdata[afs_pkg::MODE_W-1:0];
				afs_pkg::REG_MAX:  cfg_q.max_frame <= pwdata[afs_pkg::FRAME_W-1:0] & FMASK;
				afs_pkg::REG_MIN:  cfg_q.min_frame <= pwdata[afs_pkg::FRAME_W-1:0] & FMASK;
				afs_pkg::REG_RATE: cfg_q.rate <= pwdata[afs_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			afs_pkg::REG_MODE: prdata = afs_pkg::DATA_W'(cfg_q.mode);
			afs_pkg::REG_MAX:  prdata = afs_pkg::DATA_W'(cfg_q.max_frame);
			afs_pkg::REG_MIN:  prdata = afs_pkg::DATA_W'(cfg_q.min_frame);
			afs_pkg::REG_RATE: prdata = afs_pkg::DATA_W'(cfg_q.rate);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> design/afs_core.sv
// Sequencer and datapath of the frame sequencer: one request at a time,
// all sums, compares and the wrap remainder go through one afs_alu.
// Depends on afs_pkg and afs_alu.
module afs_core #(
	parameter int FRAME_BITS = afs_pkg::DEF_FRAME_BITS,
	parameter int FRAC_BITS  = afs_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  afs_pkg::in_item_t  item,
	input  afs_pkg::cfg_t      cfg,
	input  logic               slot_free,
	output logic               busy,
	output logic               done,
	output afs_pkg::out_item_t result
);

	localparam int PW     = (FRAME_BITS < afs_pkg::FRAME_W) ? FRAME_BITS : afs_pkg::FRAME_W;
	localparam int SHIFT  = afs_pkg::PROD_FRAC - FRAC_BITS;
	localparam int STEP_W = afs_pkg::PROD_W - SHIFT;
	localparam int SUM_W  = ((PW > STEP_W) ? PW : STEP_W) + 1;
	localparam int CNT_W  = $clog2(SUM_W);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_FIRST  = 3'd2;
	localparam logic [2:0] ST_CMP    = 3'd3;
	localparam logic [2:0] ST_SPAN   = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_ADDMIN = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]                   state_q;
	logic [PW-1:0]                pos_q;
	logic [afs_pkg::RUN_W-1:0]    run_q;
	logic                         rev_q;
	logic                         down_q;
	logic [afs_pkg::DELTA_W-1:0]  delta_q;
	logic [STEP_W-1:0]            step_q;
	logic [SUM_W-1:0]             acc_q;
	logic [SUM_W-1:0]             rem_q;
	logic [SUM_W-1:0]             dvd_q;
	logic [PW-1:0]                span_q;
	logic [CNT_W-1:0]             cnt_q;

	logic [PW-1:0]                max_p;
	logic [PW-1:0]                min_p;
	logic [SUM_W-1:0]             max_x;
	logic [SUM_W-1:0]             min_x;
	logic [SUM_W-1:0]             pos_x;
	logic [SUM_W-1:0]             step_x;
	logic [SUM_W-1:0]             span_x;
	logic [SUM_W-1:0]             rem_sh;
	logic [afs_pkg::PROD_W-1:0]   prod;
	logic [afs_pkg::FRAME_W+PW-1:0] frame_wide;

	logic [SUM_W-1:0] alu_a;
	logic [SUM_W-1:0] alu_b;
	logic             alu_sub;
	logic [SUM_W-1:0] alu_res;
	logic             alu_borrow;
	logic             alu_zero;

	// Bound registers hold values already trimmed to the position width.
	assign max_p  = cfg.max_frame[PW-1:0];
	assign min_p  = cfg.min_frame[PW-1:0];
	assign max_x  = {{(SUM_W-PW){1'b0}}, max_p};
	assign min_x  = {{(SUM_W-PW){1'b0}}, min_p};
	assign pos_x  = {{(SUM_W-PW){1'b0}}, pos_q};
	assign span_x = {{(SUM_W-PW){1'b0}}, span_q};
	assign step_x = {{(SUM_W-STEP_W){1'b0}}, step_q};
	assign rem_sh = {rem_q[SUM_W-2:0], dvd_q[SUM_W-1]};
	assign prod   = cfg.rate * delta_q;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_FIRST: begin
				alu_a   = pos_x;
				alu_b   = step_x;
				alu_sub = down_q;
			end
			ST_CMP: begin
				alu_sub = 1'b1;
				if (down_q) begin
					alu_a = min_x;
					alu_b = acc_q;
				end else begin
					alu_a = acc_q;
					alu_b = max_x;
				end
			end
			ST_SPAN: begin
				alu_a   = max_x;
				alu_b   = min_x;
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = rem_sh;
				alu_b   = span_x;
				alu_sub = 1'b1;
			end
			ST_ADDMIN: begin
				alu_a = min_x;
				alu_b = rem_q;
			end
			default: ;
		endcase
	end

	afs_alu #(.W(SUM_W)) u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.sub    (alu_sub),
		.res    (alu_res),
		.borrow (alu_borrow),
		.zero   (alu_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			run_q   <= afs_pkg::RUN_STOPPED;
			rev_q   <= 1'b0;
			down_q  <= 1'b0;
			delta_q <= '0;
			step_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			span_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						delta_q <= item.delta;
						state_q <= ST_DONE;
						case (item.op)
							afs_pkg::OP_TICK: begin
								if (run_q == afs_pkg::RUN_PLAYING) begin
									state_q <= ST_MUL;
								end else if (run_q == afs_pkg::RUN_STOP_REQ) begin
									run_q <= afs_pkg::RUN_STOPPED;
								end
							end
							afs_pkg::OP_PLAY: run_q <= afs_pkg::RUN_PLAYING;
							afs_pkg::OP_REQ_STOP: begin
								if (run_q == afs_pkg::RUN_PLAYING) begin
									run_q <= afs_pkg::RUN_STOP_REQ;
								end
							end
							afs_pkg::OP_STOP: run_q <= afs_pkg::RUN_STOPPED;
							afs_pkg::OP_RESTART: begin
								pos_q <= (cfg.mode == afs_pkg::MODE_BACK) ? max_p : min_p;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					step_q  <= prod[afs_pkg::PROD_W-1:SHIFT];
					down_q  <= (cfg.mode == afs_pkg::MODE_BACK) ||
						((cfg.mode == afs_pkg::MODE_ALT) && rev_q);
					state_q <= ST_FIRST;
				end
				ST_FIRST: begin
					// A step that reaches or passes zero lands on min.
					if (down_q && (alu_borrow || alu_zero)) begin
						pos_q   <= min_p;
						state_q <= ST_DONE;
						if (cfg.mode == afs_pkg::MODE_BACK) begin
							run_q <= afs_pkg::RUN_STOPPED;
						end else begin
							rev_q <= 1'b0;
						end
					end else begin
						acc_q   <= alu_res;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_DONE;
					if (down_q) begin
						if (!alu_borrow) begin
							pos_q <= min_p;
							if (cfg.mode == afs_pkg::MODE_BACK) begin
								run_q <= afs_pkg::RUN_STOPPED;
							end else begin
								rev_q <= 1'b0;
							end
						end else begin
							pos_q <= acc_q[PW-1:0];
						end
					end else if (alu_borrow) begin
						pos_q <= acc_q[PW-1:0];
					end else begin
						case (cfg.mode)
							afs_pkg::MODE_FWD: begin
								pos_q <= max_p;
								run_q <= afs_pkg::RUN_STOPPED;
							end
							afs_pkg::MODE_ALT: begin
								pos_q <= max_p;
								rev_q <= 1'b1;
							end
							afs_pkg::MODE_LOOP: begin
								dvd_q   <= alu_res;
								state_q <= ST_SPAN;
							end
							default: ;
						endcase
					end
				end
				ST_SPAN: begin
					// An empty or inverted range snaps the loop to min.
					if (alu_borrow || alu_zero) begin
						pos_q   <= min_p;
						state_q <= ST_DONE;
					end else begin
						span_q  <= alu_res[PW-1:0];
						rem_q   <= '0;
						cnt_q   <= CNT_W'(SUM_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// Restoring division, one dividend bit per cycle; only the
					// remainder of the overshoot past max is kept.
					rem_q <= alu_borrow ? rem_sh : alu_res;
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= ST_ADDMIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_ADDMIN: begin
					pos_q   <= alu_res[PW-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE) && slot_free;

	assign frame_wide        = {{afs_pkg::FRAME_W{1'b0}}, pos_q};
	assign result.frame      = frame_wide[afs_pkg::FRAME_W-1:0];
	assign result.run_status = run_q;
	assign result.going_back = rev_q;

endmodule

>>> design/animation_frame_sequencer.sv
// Top level of the animation frame sequencer: request and result channels,
// result register and configuration port. Depends on afs_pkg, afs_regs, afs_core.
//
// Usage: each request on the in channel (in_valid, in_stall, in_data) carries an op (tick,
// play, request stop, stop now, restart) and a delta for ticks. Every request yields exactly
// one result on the out channel (out_valid, out_stall, out_data) with the frame position,
// run status and alternate direction after the request. A request is taken when valid is
// high and stall is low. The block works on one request at a time and raises in_stall while busy.
// Steps per request: play, stop, restart and ticks while not playing go straight to the
// result; a playing tick takes the rate*delta step, then adds or subtracts it, and unless a
// downward step reaches or passes zero compares the sum with the bound; a loop-mode tick
// that reaches max then takes the span max - min, snaps to min if max is not above min,
// and else runs the remainder loop over SUM_W bits, one bit per cycle through the single
// shared adder, and adds min; SUM_W is the width of the position sum.
// A new request is taken in the cycle after the result is registered.
// The result sits in an output register; if the receiver stalls, the block finishes its
// work and then waits until that register is free.
// Reset clears position, run state and direction, sets mode to forward, both bounds to
// zero and the rate to 1.0. The user must write registers over the APB port only while no
// request is in flight; the block itself does not enforce it.
module animation_frame_sequencer #(
	parameter int FRAME_BITS = afs_pkg::DEF_FRAME_BITS,
	parameter int FRAC_BITS  = afs_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  afs_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output afs_pkg::out_item_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afs_pkg::ADDR_W-1:0]  paddr,
	input  logic [afs_pkg::DATA_W-1:0]  pwdata,
	output logic [afs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	afs_pkg::cfg_t      cfg;
	afs_pkg::out_item_t result;
	afs_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               busy;
	logic               done;
	logic               start;
	logic               slot_free;

	// The core may hand over a result when the output register is empty or
	// is being emptied in this cycle.
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = busy;
	assign start     = in_valid && !busy;

	afs_regs #(.FRAME_BITS(FRAME_BITS)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	afs_core #(
		.FRAME_BITS (FRAME_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (in_data),
		.cfg       (cfg),
		.slot_free (slot_free),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	// Output register: loaded when the core finishes, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sim/animation_frame_sequencer_tb.sv
// Self-checking testbench of the animation frame sequencer: directed and random requests,
// an in-bench frame predictor, random idling on both channels and APB register phases.
// Depends on afs_pkg and the animation_frame_sequencer RTL.
module animation_frame_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afs_pkg::*;

	// Op codes that the block must ignore.
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	// Right shift that brings the Q10.16 rate*delta product into frame format.
	localparam int STRIDE_SHIFT = PROD_FRAC - DEF_FRAC_BITS;
	// The slowest request is a wrapping loop tick; the drain pause at the end covers it
	// with margin.
	localparam int DRAIN_CYCLES = 40;
	// The watchdog limit lies well above what a correct run needs, even with every result stalled.
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_CAP = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Mirror of the configuration registers, kept in step with every APB write.
	logic [MODE_W-1:0]  cfg_mode = MODE_FWD;
	logic [FRAME_W-1:0] cfg_max = '0;
	logic [FRAME_W-1:0] cfg_min = '0;
	logic [RATE_W-1:0]  cfg_rate = RATE_RESET;

	// Predicted state of the sequencer.
	logic [FRAME_W-1:0] cur_pos = '0;
	logic [RUN_W-1:0]   cur_run = RUN_STOPPED;
	logic               cur_back = 1'b0;

	// Requests waiting to be driven, and the results that accepted requests owe.
	in_item_t  pending_reqs[$];
	out_item_t expected_frames[$];

	int fail_count = 0;
	int cycle_count = 0;
	int sent_count = 0;
	// Percent chance of starting an idle burst; zero gives a stretch without idling.
	int idle_odds = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit drain_hold = 1'b0;

	animation_frame_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #6 clk = ~clk;

	// Moving toward max: the position clamps at max, and the caller learns whether
	// the end was reached.
	function automatic bit climb(input logic [63:0] stride, inout logic [63:0] spot);
		logic [63:0] total;
		total = spot + stride;
		if (total >= 64'(cfg_max)) begin
			spot = 64'(cfg_max);
			return 1'b1;
		end
		spot = total;
		return 1'b0;
	endfunction

	// Moving toward min: a step past zero counts as reaching min as well.
	function automatic bit descend(input logic [63:0] stride, inout logic [63:0] spot);
		if (stride >= spot || spot - stride <= 64'(cfg_min)) begin
			spot = 64'(cfg_min);
			return 1'b1;
		end
		spot = spot - stride;
		return 1'b0;
	endfunction

	// Applies one request to the predicted state and returns the result it owes.
	function automatic out_item_t advance_frame(in_item_t req);
		logic [63:0] stride;
		logic [63:0] nxt;
		logic [63:0] total;
		logic [63:0] span;
		out_item_t res;
		case (req.op)
			OP_TICK: begin
				stride = (64'(cfg_rate) * 64'(req.delta)) >> STRIDE_SHIFT;
				nxt = 64'(cur_pos);
				if (cur_run == RUN_PLAYING) begin
					case (cfg_mode)
						MODE_FWD: begin
							if (climb(stride, nxt))
								cur_run = RUN_STOPPED;
						end
						MODE_BACK: begin
							if (descend(stride, nxt))
								cur_run = RUN_STOPPED;
						end
						MODE_LOOP: begin
							total = nxt + stride;
							if (total < 64'(cfg_max)) begin
								nxt = total;
							end else if (cfg_max <= cfg_min) begin
								nxt = 64'(cfg_min);
							end else begin
								// Take off as many spans as it needs to fall below max.
								span = 64'(cfg_max) - 64'(cfg_min);
								nxt = total - span * ((total - 64'(cfg_max)) / span + 64'd1);
							end
						end
						default: begin
							if (!cur_back) begin
								if (climb(stride, nxt))
									cur_back = 1'b1;
							end else begin
								if (descend(stride, nxt))
									cur_back = 1'b0;
							end
						end
					endcase
					cur_pos = nxt[FRAME_W-1:0];
				end else if (cur_run == RUN_STOP_REQ) begin
					cur_run = RUN_STOPPED;
				end
			end
			OP_PLAY: cur_run = RUN_PLAYING;
			OP_REQ_STOP: begin
				if (cur_run == RUN_PLAYING)
					cur_run = RUN_STOP_REQ;
			end
			OP_STOP: cur_run = RUN_STOPPED;
			OP_RESTART: cur_pos = (cfg_mode == MODE_BACK) ? cfg_max : cfg_min;
			default: ;
		endcase
		res.frame = cur_pos;
		res.run_status = cur_run;
		res.going_back = cur_back;
		return res;
	endfunction

	// Compares one accepted result with the oldest outstanding prediction.
	task automatic check_frame(out_item_t got);
		out_item_t want;
		if (expected_frames.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$display("unexpected result: frame %h status %0d back %0d",
					got.frame, got.run_status, got.going_back);
		end else begin
			want = expected_frames.pop_front();
			if (got.frame !== want.frame || got.run_status !== want.run_status ||
					got.going_back !== want.going_back) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$display("mismatch: frame exp %h got %h, status exp %0d got %0d, back exp %0d got %0d",
						want.frame, got.frame, want.run_status, got.run_status,
						want.going_back, got.going_back);
			end
		end
	endtask

	// Request driver. The prediction is made at the edge where the request is
	// taken, so it always sees the configuration that the block sees. After an
	// accepted request the driver may idle for a short burst, and now and then it
	// holds off until every outstanding result has come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
			drain_hold = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_frames.push_back(advance_frame(in_data));
				sent_count++;
				if (sent_count % 150 == 75)
					drain_hold = 1'b1;
				if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
					gap_left = $urandom_range(1, 4);
			end
			if (drain_hold && expected_frames.size() == 0)
				drain_hold = 1'b0;
			// A stalled request stays on the bus unchanged.
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!drain_hold && pending_reqs.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Each result taken is checked, and the receiver stalls in
	// random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall)
				check_frame(out_data);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One APB write: setup cycle, then the access cycle whose closing edge
	// writes the register. pready is always high, so there are no wait states.
	task automatic write_register(logic [1:0] idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: cfg_mode = value[MODE_W-1:0];
			REG_MAX:  cfg_max = value[FRAME_W-1:0];
			REG_MIN:  cfg_min = value[FRAME_W-1:0];
			default:  cfg_rate = value[RATE_W-1:0];
		endcase
	endtask

	task automatic apply_settings(logic [MODE_W-1:0] m, logic [FRAME_W-1:0] hi,
			logic [FRAME_W-1:0] lo, logic [RATE_W-1:0] r);
		write_register(REG_MODE, DATA_W'(m));
		write_register(REG_MAX, DATA_W'(hi));
		write_register(REG_MIN, DATA_W'(lo));
		write_register(REG_RATE, DATA_W'(r));
	endtask

	task automatic queue_request(logic [OP_W-1:0] o, logic [DELTA_W-1:0] d);
		in_item_t req;
		req.op = o;
		req.delta = d;
		pending_reqs.push_back(req);
	endtask

	// Registers may only change once the block has nothing in flight.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0);
	endtask

	// Deltas lean toward the extremes and toward small steps that leave the
	// bounds far away.
	function automatic logic [DELTA_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DELTA_W'($urandom_range(1, 64));
			default: return DELTA_W'($urandom);
		endcase
	endfunction

	// Bounds and rate for one random phase: wide, narrow, inverted, full range
	// and a one-step span all come up.
	task automatic random_settings();
		logic [MODE_W-1:0]  m;
		logic [FRAME_W-1:0] hi;
		logic [FRAME_W-1:0] lo;
		logic [RATE_W-1:0]  r;
		m = MODE_W'($urandom_range(MODE_FWD, MODE_ALT));
		case ($urandom_range(0, 4))
			0: begin
				hi = FRAME_W'($urandom);
				lo = FRAME_W'($urandom);
			end
			1: begin
				lo = FRAME_W'($urandom_range(0, 20'hF0000));
				hi = lo + FRAME_W'($urandom_range(1, 20'h3000));
			end
			2: begin
				lo = FRAME_W'($urandom);
				hi = lo >> $urandom_range(0, 4);
			end
			3: begin
				hi = '1;
				lo = '0;
			end
			default: begin
				lo = FRAME_W'($urandom);
				hi = lo + 1'b1;
			end
		endcase
		case ($urandom_range(0, 3))
			0: r = RATE_W'($urandom);
			1: r = '0;
			2: r = '1;
			default: r = RATE_W'($urandom_range(16'h0040, 16'h0400));
		endcase
		apply_settings(m, hi, lo, r);
	endtask

	// Mostly well-formed play sequences (restart, play, a run of ticks with the
	// odd stop or replay), with some noise including the ignored op codes.
	task automatic queue_random_phase(int count);
		int made;
		int burst;
		int pick;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 99) < 6) begin
				queue_request(OP_W'($urandom_range(OP_TICK, OP_SPARE_LAST)), pick_delta());
				made++;
			end else begin
				if ($urandom_range(0, 4) != 0) begin
					queue_request(OP_RESTART, pick_delta());
					made++;
				end
				queue_request(OP_PLAY, pick_delta());
				made++;
				burst = $urandom_range(3, 16);
				repeat (burst) begin
					pick = $urandom_range(0, 99);
					if (pick < 84)
						queue_request(OP_TICK, pick_delta());
					else if (pick < 91)
						queue_request(OP_REQ_STOP, pick_delta());
					else if (pick < 95)
						queue_request(OP_STOP, pick_delta());
					else
						queue_request(OP_PLAY, pick_delta());
					made++;
				end
			end
		end
	endtask

	initial begin
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		idle_odds = 15;

		// Reset configuration: forward, both bounds zero, rate 1.0. Ignored op
		// codes, a stop request while stopped and a tick while stopped change
		// nothing; a forward tick with max at zero clamps and stops at once.
		queue_request(OP_SPARE_FIRST, '1);
		queue_request(OP_SPARE_LAST, '0);
		queue_request(OP_REQ_STOP, '1);
		queue_request(OP_TICK, '1);
		queue_request(OP_PLAY, '1);
		queue_request(OP_TICK, DELTA_W'(256));
		wait_drained();

		// Backward at full range and full rate: restart goes to max, and the last
		// tick steps below zero, which counts as reaching min.
		apply_settings(MODE_BACK, '1, '0, '1);
		queue_request(OP_RESTART, '0);
		queue_request(OP_PLAY, '0);
		repeat (5) queue_request(OP_TICK, '1);
		wait_drained();

		// Loop with max below min: reaching max sets the frame to min.
		apply_settings(MODE_LOOP, FRAME_W'(20'h00200), FRAME_W'(20'h00800),
			RATE_W'(16'h0100));
		queue_request(OP_RESTART, '1);
		queue_request(OP_PLAY, '0);
		queue_request(OP_TICK, DELTA_W'(1));
		wait_drained();

		// Loop wrap over a narrow span, many spans at once.
		apply_settings(MODE_LOOP, FRAME_W'(20'h01000), FRAME_W'(20'h00F00), '1);
		queue_request(OP_RESTART, '0);
		queue_request(OP_PLAY, '0);
		queue_request(OP_TICK, '1);
		queue_request(OP_TICK, '1);
		wait_drained();

		// Alternate: bounce off max, then a stop request that lands on the next
		// tick, and an immediate stop.
		apply_settings(MODE_ALT, FRAME_W'(20'h01000), FRAME_W'(20'h00100),
			RATE_W'(16'h0800));
		queue_request(OP_RESTART, '0);
		queue_request(OP_PLAY, '0);
		repeat (3) queue_request(OP_TICK, DELTA_W'(256));
		queue_request(OP_REQ_STOP, '0);
		queue_request(OP_TICK, DELTA_W'(256));
		queue_request(OP_STOP, '0);
		wait_drained();

		// Random phases, each under fresh settings. Two of them, the last among
		// them, run with no idling on either side.
		for (phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 2))
				0: idle_odds = 5;
				1: idle_odds = 15;
				default: idle_odds = 35;
			endcase
			if (phase == 5 || phase == 11)
				idle_odds = 0;
			if (phase == 11)
				apply_settings(MODE_LOOP, '1, '0, '1);
			else
				random_settings();
			queue_random_phase(100);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
